// ===== rtl/bcs_pkg.sv =====
// bcs_pkg: shared types and constants for the bootloader client sequencer
// no dependencies; imported by every rtl file of the block
package bcs_pkg;

  // operation codes of an input word
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;

  // reply codes in frame byte 15
  localparam logic [7:0] REPLY_ERASE_DONE = 8'd1;
  localparam logic [7:0] REPLY_SEND_MORE  = 8'd2;
  localparam logic [7:0] REPLY_MAC        = 8'd3;
  localparam logic [7:0] REPLY_IP         = 8'd4;

  // frame filter constants
  localparam logic [47:0] RADIO_MAC     = 48'h11_22_33_44_55_66;
  localparam logic [23:0] BOOT_TAG      = 24'hEF_FE_03;
  localparam logic [10:0] MIN_FRAME_LEN = 11'd22;

  // result event codes
  localparam logic [1:0] EV_COMMAND  = 2'd0;
  localparam logic [1:0] EV_BLOCK    = 2'd1;
  localparam logic [1:0] EV_FINISHED = 2'd2;
  localparam logic [1:0] EV_TIMEOUT  = 2'd3;

  // command codes
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_PROGRAM  = 3'd1;
  localparam logic [2:0] CMD_ERASE    = 3'd2;
  localparam logic [2:0] CMD_READ_MAC = 3'd3;
  localparam logic [2:0] CMD_READ_IP  = 3'd4;
  localparam logic [2:0] CMD_WRITE_IP = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_MAC        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_IP          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURN_IP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRMWARE_BLOCKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_TIMEOUT   = 3'd5;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [14:0] REPLY_TIMEOUT_RST = 15'd50;
  localparam logic [14:0] ERASE_TIMEOUT_RST = 15'd18000;

  // class of a word after the front end has looked at it
  typedef enum logic [2:0] {
    CL_START,
    CL_TICK,
    CL_MAC,
    CL_IP,
    CL_BLOCK,
    CL_NONE
  } item_class_t;

  typedef struct packed {
    logic [47:0] host_mac;
    logic [31:0] new_ip;
    logic        burn_ip;
    logic [15:0] firmware_blocks;
    logic [14:0] reply_timeout;
    logic [14:0] erase_timeout;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  command_code;
    logic [15:0] block_index;
    logic [31:0] ip_payload;
  } result_t;

endpackage

// ===== rtl/bcs_if.sv =====
// bcs_if: valid/ready channel interfaces for input words, result words and
// configuration writes; depends on bcs_pkg
interface bcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [10:0] frame_length;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [23:0] protocol_tag;
  logic [7:0]  reply_code;

  modport source (output valid, operation, frame_length, dest_mac, source_mac,
                  protocol_tag, reply_code, input ready);
  modport sink (input valid, operation, frame_length, dest_mac, source_mac,
                protocol_tag, reply_code, output ready);
endinterface

interface bcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [2:0]  command_code;
  logic [15:0] block_index;
  logic [31:0] ip_payload;
  logic        last;

  modport source (output valid, event_res, command_code, block_index, ip_payload, last,
                  input ready);
  modport sink (input valid, event_res, command_code, block_index, ip_payload, last,
                output ready);
endinterface

interface bcs_cfg_if
  import bcs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bcs_front.sv =====
// bcs_front: accepts input words, runs the frame filter and decodes the reply
// depends on bcs_pkg and bcs_if
module bcs_front
  import bcs_pkg::*;
(
  bcs_in_if.sink      in_ch,
  input  logic [47:0] host_mac,
  output logic        push_valid,
  output item_class_t push_class,
  input  logic        push_ready
);

  logic frame_ok;

  assign frame_ok = (in_ch.frame_length > MIN_FRAME_LEN) &&
                    (in_ch.dest_mac == host_mac) &&
                    (in_ch.source_mac == RADIO_MAC) &&
                    (in_ch.protocol_tag == BOOT_TAG);

  always_comb begin
    push_class = CL_NONE;
    unique case (in_ch.operation)
      OP_START: push_class = CL_START;
      OP_TICK:  push_class = CL_TICK;
      OP_FRAME: begin
        if (frame_ok) begin
          unique case (in_ch.reply_code)
            REPLY_MAC:        push_class = CL_MAC;
            REPLY_IP:         push_class = CL_IP;
            REPLY_ERASE_DONE: push_class = CL_BLOCK;
            REPLY_SEND_MORE:  push_class = CL_BLOCK;
            default:          push_class = CL_NONE;
          endcase
        end
      end
      default: push_class = CL_NONE;
    endcase
  end

  // words that can never cause anything are taken and dropped here
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && (push_class != CL_NONE);

endmodule

// ===== rtl/bcs_queue.sv =====
// bcs_queue: small fifo of classified words between front and back end
// depends on bcs_pkg
module bcs_queue
  import bcs_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  input  item_class_t push_class,
  output logic        push_ready,
  output logic        head_valid,
  output item_class_t head_class,
  input  logic        pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_class_t       slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_class = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_class;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bcs_back.sv =====
// bcs_back: exchange state, reply timer, block counter and result register
// depends on bcs_pkg and bcs_if
module bcs_back
  import bcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_regs_t   cfg_regs,
  input  logic        head_valid,
  input  item_class_t head_class,
  output logic        pop,
  bcs_out_if.source   out_ch
);

  typedef enum logic {PH_IDLE, PH_WAIT} phase_t;

  phase_t      phase, phase_next;
  logic [14:0] wait_count, wait_count_next;
  logic [15:0] blocks_sent, blocks_sent_next;
  logic        second;
  logic        out_valid;
  result_t     out_res;
  logic        out_last;

  logic        has_res;
  logic        two_res;
  result_t     first_res;
  result_t     final_res;
  logic        can_load;
  logic        load;
  logic        load_first;

  function automatic result_t mk(input logic [1:0] ev, input logic [2:0] cmd,
                                 input logic [15:0] blk, input logic [31:0] ip);
    result_t r;
    r.event_res    = ev;
    r.command_code = cmd;
    r.block_index  = blk;
    r.ip_payload   = ip;
    return r;
  endfunction

  always_comb begin
    has_res          = 1'b0;
    two_res          = 1'b0;
    first_res        = mk(EV_COMMAND, CMD_WRITE_IP, 16'd0, cfg_regs.new_ip);
    final_res        = mk(EV_FINISHED, CMD_NONE, 16'd0, 32'd0);
    phase_next       = phase;
    wait_count_next  = wait_count;
    blocks_sent_next = blocks_sent;
    unique case (head_class)
      CL_START: begin
        has_res          = 1'b1;
        final_res        = mk(EV_COMMAND, CMD_READ_MAC, 16'd0, 32'd0);
        phase_next       = PH_WAIT;
        blocks_sent_next = '0;
        wait_count_next  = cfg_regs.reply_timeout;
      end
      CL_TICK: begin
        if (phase == PH_WAIT) begin
          if (wait_count <= 15'd1) begin
            has_res         = 1'b1;
            final_res       = mk(EV_TIMEOUT, CMD_NONE, 16'd0, 32'd0);
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end else begin
            wait_count_next = wait_count - 15'd1;
          end
        end
      end
      CL_MAC: begin
        if (phase == PH_WAIT) begin
          has_res         = 1'b1;
          final_res       = mk(EV_COMMAND, CMD_READ_IP, 16'd0, 32'd0);
          wait_count_next = cfg_regs.reply_timeout;
        end
      end
      CL_IP: begin
        if (phase == PH_WAIT) begin
          has_res = 1'b1;
          two_res = cfg_regs.burn_ip;
          if (cfg_regs.firmware_blocks != 16'd0) begin
            final_res       = mk(EV_COMMAND, CMD_ERASE, 16'd0, 32'd0);
            wait_count_next = cfg_regs.erase_timeout;
          end else begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end
        end
      end
      CL_BLOCK: begin
        if (phase == PH_WAIT) begin
          has_res = 1'b1;
          if (blocks_sent >= cfg_regs.firmware_blocks) begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end else begin
            final_res        = mk(EV_BLOCK, CMD_PROGRAM, blocks_sent, 32'd0);
            blocks_sent_next = blocks_sent + 16'd1;
            wait_count_next  = cfg_regs.reply_timeout;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // a two-result word holds the queue head until its second result is loaded
  assign can_load   = !out_valid || out_ch.ready;
  assign load       = head_valid && has_res && can_load;
  assign load_first = load && two_res && !second;
  assign pop        = head_valid && (!has_res || can_load) && !(two_res && !second);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      wait_count  <= '0;
      blocks_sent <= '0;
      second      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        wait_count  <= wait_count_next;
        blocks_sent <= blocks_sent_next;
        second      <= 1'b0;
      end else if (load_first) begin
        second <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
        out_res   <= load_first ? first_res : final_res;
        out_last  <= !load_first;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.event_res    = out_res.event_res;
  assign out_ch.command_code = out_res.command_code;
  assign out_ch.block_index  = out_res.block_index;
  assign out_ch.ip_payload   = out_res.ip_payload;
  assign out_ch.last         = out_last;

endmodule

// ===== rtl/bootloader_client_sequencer.sv =====
// bootloader_client_sequencer: top level, configuration registers and the
// front / queue / back split; depends on bcs_pkg, bcs_if and the bcs_* modules
//
//   channel  direction  words                              handshake
//   in_ch    in         start, tick or received frame hdr  valid/ready
//   out_ch   out        command, data block, finish, tmo   valid/ready, last
//   cfg      in         register index and write data      valid/ready
//
// an input word is taken every cycle while the queue has room; the front end
// classifies it in the accepting cycle and the back end retires one queue word per
// cycle while out_ch is not stalled; the ip reply with ip write enabled puts two
// words on out_ch, the write first, and holds the queue head until both are loaded
// rst is synchronous: queue empty, phase idle, timer and block count zero,
// registers at their reset values (reply timeout 50, erase timeout 18000)
// a stalled out_ch backs up the queue, then in_ch; cfg is always ready
module bootloader_client_sequencer
  import bcs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  bcs_in_if.sink      in_ch,
  bcs_out_if.source   out_ch,
  bcs_cfg_if.sink     cfg
);

  cfg_regs_t   cfg_regs;
  logic        push_valid;
  item_class_t push_class;
  logic        push_ready;
  logic        head_valid;
  item_class_t head_class;
  logic        pop;

  // register file; the user writes it only while the exchange is quiet (not enforced)
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.host_mac        <= '0;
      cfg_regs.new_ip          <= '0;
      cfg_regs.burn_ip         <= 1'b0;
      cfg_regs.firmware_blocks <= '0;
      cfg_regs.reply_timeout   <= REPLY_TIMEOUT_RST;
      cfg_regs.erase_timeout   <= ERASE_TIMEOUT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HOST_MAC:        cfg_regs.host_mac        <= cfg.data[47:0];
        REG_NEW_IP:          cfg_regs.new_ip          <= cfg.data[31:0];
        REG_BURN_IP:         cfg_regs.burn_ip         <= cfg.data[0];
        REG_FIRMWARE_BLOCKS: cfg_regs.firmware_blocks <= cfg.data[15:0];
        REG_REPLY_TIMEOUT:   cfg_regs.reply_timeout   <= cfg.data[14:0];
        REG_ERASE_TIMEOUT:   cfg_regs.erase_timeout   <= cfg.data[14:0];
        default: begin
          // indexes past the list are dropped
        end
      endcase
    end
  end

  // front end: filter and reply decode, drops words that cannot matter
  bcs_front u_front (
    .in_ch      (in_ch),
    .host_mac   (cfg_regs.host_mac),
    .push_valid (push_valid),
    .push_class (push_class),
    .push_ready (push_ready)
  );

  // decoupling queue
  bcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_class (push_class),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_class (head_class),
    .pop        (pop)
  );

  // back end: exchange state machine and result register
  bcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .head_valid (head_valid),
    .head_class (head_class),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/bcs_checker.sv =====
// bcs_checker: port-level assertions for bootloader_client_sequencer
// depends on bcs_pkg; attached to the top level by the bind at the end
module bcs_checker
  import bcs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_res,
  input logic [2:0]  command_code,
  input logic [15:0] block_index,
  input logic [31:0] ip_payload,
  input logic        last,
  input logic        cfg_ready
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) &&
      $stable(command_code) && $stable(block_index) && $stable(ip_payload) &&
      $stable(last))
    else $error("result word changed while stalled");

  // the ip write is followed at once by erase or finish
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid &&
      ((event_res == EV_FINISHED) || (command_code == CMD_ERASE)))
    else $error("ip write not followed by erase or finish");

  // nothing is shown right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // configuration port never stalls
  assert property (@(posedge clk) disable iff (rst) $past(!rst) |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind bootloader_client_sequencer bcs_checker u_bcs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_res    (out_ch.event_res),
  .command_code (out_ch.command_code),
  .block_index  (out_ch.block_index),
  .ip_payload   (out_ch.ip_payload),
  .last         (out_ch.last),
  .cfg_ready    (cfg.ready)
);

// ===== sim/bcs_exchange_monitor.sv =====
`timescale 1ns / 1ps
// bcs_exchange_monitor: watches the input, result and register channels, predicts the
// result words of the bootloader client sequencer and compares them in order
// depends on bcs_pkg and the channel interfaces of bcs_if
module bcs_exchange_monitor
  import bcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bcs_in_if           in_ch,
  bcs_out_if          out_ch,
  bcs_cfg_if          cfg,
  output int unsigned pending_words,
  output int unsigned mismatches
);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_WAIT
  } seq_phase_t;

  typedef struct packed {
    result_t word;
    logic    last;
  } awaited_t;

  localparam int unsigned REPORT_LIMIT = 10;

  cfg_regs_t   regs;
  seq_phase_t  phase;
  logic [14:0] ticks_left;
  logic [15:0] blocks_done;
  awaited_t    awaited_words[$];
  int unsigned fail_total = 0;

  function automatic void note_failure(string msg);
    if (fail_total < REPORT_LIMIT) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    fail_total++;
  endfunction

  function automatic void push_word(logic [1:0] ev, logic [2:0] cmd, logic [15:0] blk,
                                    logic [31:0] ip);
    awaited_t w;
    w.word.event_res    = ev;
    w.word.command_code = cmd;
    w.word.block_index  = blk;
    w.word.ip_payload   = ip;
    w.last              = 1'b0;
    awaited_words.push_back(w);
  endfunction

  function automatic void finish_exchange();
    phase      = SEQ_IDLE;
    ticks_left = '0;
    push_word(EV_FINISHED, CMD_NONE, '0, '0);
  endfunction

  // erase done and send more both ask for the next block
  function automatic void next_block_or_finish();
    if (blocks_done >= regs.firmware_blocks) begin
      finish_exchange();
    end else begin
      push_word(EV_BLOCK, CMD_PROGRAM, blocks_done, '0);
      blocks_done = blocks_done + 16'd1;
      ticks_left  = regs.reply_timeout;
    end
  endfunction

  function automatic void predict_word();
    int unsigned base;
    logic        header_ok;
    base = awaited_words.size();
    case (in_ch.operation)
      OP_START: begin
        phase       = SEQ_WAIT;
        blocks_done = '0;
        ticks_left  = regs.reply_timeout;
        push_word(EV_COMMAND, CMD_READ_MAC, '0, '0);
      end
      OP_TICK: begin
        if (phase == SEQ_WAIT) begin
          if (ticks_left <= 15'd1) begin
            phase      = SEQ_IDLE;
            ticks_left = '0;
            push_word(EV_TIMEOUT, CMD_NONE, '0, '0);
          end else begin
            ticks_left = ticks_left - 15'd1;
          end
        end
      end
      OP_FRAME: begin
        header_ok = (phase == SEQ_WAIT) && (in_ch.frame_length > MIN_FRAME_LEN) &&
                    (in_ch.dest_mac == regs.host_mac) && (in_ch.source_mac == RADIO_MAC) &&
                    (in_ch.protocol_tag == BOOT_TAG);
        if (header_ok) begin
          case (in_ch.reply_code)
            REPLY_MAC: begin
              ticks_left = regs.reply_timeout;
              push_word(EV_COMMAND, CMD_READ_IP, '0, '0);
            end
            REPLY_IP: begin
              if (regs.burn_ip) begin
                push_word(EV_COMMAND, CMD_WRITE_IP, '0, regs.new_ip);
              end
              if (regs.firmware_blocks != '0) begin
                ticks_left = regs.erase_timeout;
                push_word(EV_COMMAND, CMD_ERASE, '0, '0);
              end else begin
                finish_exchange();
              end
            end
            REPLY_ERASE_DONE, REPLY_SEND_MORE: next_block_or_finish();
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (awaited_words.size() > base) begin
      awaited_words[awaited_words.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_word();
    awaited_t want;
    awaited_t got;
    got = {out_ch.event_res, out_ch.command_code, out_ch.block_index, out_ch.ip_payload,
           out_ch.last};
    if (awaited_words.size() == 0) begin
      note_failure($sformatf("unexpected word ev=%0d cmd=%0d blk=%0d ip=%h last=%0d",
                             got.word.event_res, got.word.command_code,
                             got.word.block_index, got.word.ip_payload, got.last));
    end else begin
      want = awaited_words.pop_front();
      if (got !== want) begin
        note_failure($sformatf(
          "expected ev=%0d cmd=%0d blk=%0d ip=%h last=%0d got ev=%0d cmd=%0d blk=%0d ip=%h last=%0d",
          want.word.event_res, want.word.command_code, want.word.block_index,
          want.word.ip_payload, want.last, got.word.event_res, got.word.command_code,
          got.word.block_index, got.word.ip_payload, got.last));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.host_mac        = '0;
      regs.new_ip          = '0;
      regs.burn_ip         = 1'b0;
      regs.firmware_blocks = '0;
      regs.reply_timeout   = REPLY_TIMEOUT_RST;
      regs.erase_timeout   = ERASE_TIMEOUT_RST;
      phase                = SEQ_IDLE;
      ticks_left           = '0;
      blocks_done          = '0;
      awaited_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_word();
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HOST_MAC:        regs.host_mac        = cfg.data[47:0];
          REG_NEW_IP:          regs.new_ip          = cfg.data[31:0];
          REG_BURN_IP:         regs.burn_ip         = cfg.data[0];
          REG_FIRMWARE_BLOCKS: regs.firmware_blocks = cfg.data[15:0];
          REG_REPLY_TIMEOUT:   regs.reply_timeout   = cfg.data[14:0];
          REG_ERASE_TIMEOUT:   regs.erase_timeout   = cfg.data[14:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_word();
      end
    end
    pending_words <= awaited_words.size();
    mismatches    <= fail_total;
  end

endmodule

// ===== sim/tb_bootloader_client_sequencer.sv =====
`timescale 1ns / 1ps
// tb_bootloader_client_sequencer: stimulus and verdict for the bootloader client
// sequencer; depends on bcs_pkg, bcs_if, the rtl and bcs_exchange_monitor
module tb_bootloader_client_sequencer
  import bcs_pkg::*;
;

  localparam int unsigned PHASES          = 6;
  localparam int unsigned WORDS_PER_PHASE = 250;
  localparam int unsigned SETTLE_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;

  // operation code the block must ignore, and a reply code it does not know
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [7:0] REPLY_UNKNOWN = 8'hFF;

  logic clk;
  logic rst;

  bcs_in_if  in_ch ();
  bcs_out_if out_ch ();
  bcs_cfg_if cfg_ch ();

  int unsigned pending_words;
  int unsigned mismatches;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;
  logic [47:0] host_mac_now = '0;

  bootloader_client_sequencer i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  bcs_exchange_monitor i_monitor (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg           (cfg_ch),
    .pending_words (pending_words),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: runs of ready broken by stall bursts, which occur only while idle_on is set
  initial begin
    int unsigned run;
    run = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        if (idle_on && $urandom_range(0, 3) == 0) begin
          out_ch.ready <= 1'b0;
          run = $urandom_range(1, 7);
        end else begin
          out_ch.ready <= 1'b1;
          run = $urandom_range(1, 12);
        end
      end
      run--;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // present one input word, maybe after an idle burst, and wait for the handshake
  task automatic send_word(logic [1:0] op, logic [10:0] len, logic [47:0] dst,
                           logic [47:0] src, logic [23:0] tag, logic [7:0] code);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.frame_length <= len;
    in_ch.dest_mac     <= dst;
    in_ch.source_mac   <= src;
    in_ch.protocol_tag <= tag;
    in_ch.reply_code   <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // frame whose addresses and tag pass the filter; the length is given by the caller
  task automatic send_frame(logic [10:0] len, logic [7:0] code);
    send_word(OP_FRAME, len, host_mac_now, RADIO_MAC, BOOT_TAG, code);
  endtask

  // hold the sender until every predicted word is out, then let the pipe empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // register settings per phase; the first four hold the extremes
  task automatic configure(int unsigned p);
    logic [47:0] mac;
    logic [31:0] ip;
    logic        burn;
    logic [15:0] blocks;
    logic [14:0] reply_t;
    logic [14:0] erase_t;
    mac     = rand48();
    ip      = $urandom;
    burn    = 1'($urandom_range(0, 1));
    blocks  = 16'($urandom_range(1, 8));
    reply_t = 15'($urandom_range(2, 6));
    erase_t = 15'($urandom_range(2, 10));
    case (p)
      0: begin
        mac     = '1;
        ip      = '1;
        burn    = 1'b1;
        blocks  = 16'd3;
        reply_t = 15'd3;
        erase_t = 15'd2;
      end
      1: begin
        // all zero, no upload, timeouts of one tick
        mac     = '0;
        ip      = '0;
        burn    = 1'b0;
        blocks  = '0;
        reply_t = 15'd1;
        erase_t = 15'd1;
      end
      2: begin
        // largest block count and timeouts: uploads never finish here
        burn    = 1'b1;
        blocks  = '1;
        reply_t = '1;
        erase_t = '1;
      end
      3: begin
        // zero timeouts: the first tick expires
        blocks  = 16'($urandom_range(1, 4));
        reply_t = '0;
        erase_t = '0;
      end
      default: ;
    endcase
    host_mac_now = mac;
    write_reg(REG_HOST_MAC, mac);
    write_reg(REG_NEW_IP, 48'(ip));
    write_reg(REG_BURN_IP, 48'(burn));
    write_reg(REG_FIRMWARE_BLOCKS, 48'(blocks));
    write_reg(REG_REPLY_TIMEOUT, 48'(reply_t));
    write_reg(REG_ERASE_TIMEOUT, 48'(erase_t));
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed frames with random reply codes, plus ticks, starts and noise
  task automatic random_word();
    int unsigned pick;
    logic [47:0] flip;
    logic [10:0] len;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    flip = rand48();
    if (flip == '0) flip = 48'd1;
    len  = 11'($urandom_range(23, 2047));
    code = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
    if (pick < 7) begin
      send_word(OP_START, 11'($urandom), rand48(), rand48(), 24'($urandom), 8'($urandom));
    end else if (pick < 30) begin
      send_word(OP_TICK, 11'($urandom), rand48(), rand48(), 24'($urandom), 8'($urandom));
    end else if (pick < 32) begin
      send_word(OP_UNUSED, 11'($urandom), rand48(), rand48(), 24'($urandom), 8'($urandom));
    end else if (pick < 86) begin
      send_frame(len, code);
    end else begin
      // broken header: exactly one filter term fails
      case (pick % 4)
        0: send_frame(11'($urandom_range(0, 22)), code);
        1: send_word(OP_FRAME, len, host_mac_now ^ flip, RADIO_MAC, BOOT_TAG, code);
        2: send_word(OP_FRAME, len, host_mac_now, RADIO_MAC ^ flip, BOOT_TAG, code);
        default: send_word(OP_FRAME, len, host_mac_now, RADIO_MAC,
                           BOOT_TAG ^ {flip[23:1], 1'b1}, code);
      endcase
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_START;
    in_ch.frame_length  <= '0;
    in_ch.dest_mac      <= '0;
    in_ch.source_mac    <= '0;
    in_ch.protocol_tag  <= '0;
    in_ch.reply_code    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_HOST_MAC;
    cfg_ch.data         <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part under the first setting: host mac all ones, three blocks,
    // ip write on, reply timeout 3, erase timeout 2
    configure(0);
    send_word(OP_TICK, '0, '0, '0, '0, '0);          // tick while idle
    send_frame(11'd2047, REPLY_MAC);                 // frame while idle
    send_word(OP_UNUSED, '1, '1, '1, '1, '1);        // unused operation
    send_word(OP_START, '0, '0, '0, '0, '0);
    send_frame(11'd22, REPLY_MAC);                   // one byte too short
    send_word(OP_FRAME, 11'd64, '0, RADIO_MAC, BOOT_TAG, REPLY_MAC);             // wrong dest
    send_word(OP_FRAME, 11'd64, host_mac_now, '1, BOOT_TAG, REPLY_MAC);          // wrong source
    send_word(OP_FRAME, 11'd64, host_mac_now, RADIO_MAC, '0, REPLY_MAC);         // wrong tag
    send_frame(11'd64, REPLY_UNKNOWN);               // unknown reply, ignored
    send_frame(11'd23, REPLY_MAC);                   // shortest length that passes
    send_frame(11'd2047, REPLY_IP);                  // ip write then erase, two words
    send_frame(11'd64, REPLY_ERASE_DONE);            // block 0
    send_frame(11'd64, REPLY_SEND_MORE);             // block 1
    send_frame(11'd64, REPLY_SEND_MORE);             // block 2
    send_frame(11'd64, REPLY_SEND_MORE);             // all blocks sent: finished
    send_word(OP_START, '1, '1, '1, '1, '1);
    send_frame(11'd64, REPLY_MAC);
    send_word(OP_START, '0, '0, '0, '0, '0);         // restart while waiting
    send_word(OP_TICK, '1, '1, '1, '1, '1);
    send_word(OP_TICK, '0, '0, '0, '0, '0);
    send_word(OP_TICK, '1, '1, '1, '1, '1);          // third tick expires
    drain();

    // random part, one register setting per phase; the last phase runs without idling
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p != 0) configure(p);
      if (p == PHASES - 1) idle_on = 1'b0;
      for (int unsigned i = 0; i < WORDS_PER_PHASE; i++) begin
        if (i % 40 == 0 && p != PHASES - 1) idle_on = ($urandom_range(0, 3) != 0);
        random_word();
        if (p != PHASES - 1 && $urandom_range(0, 149) == 0) drain();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
